[design/prlsf_pkg.sv]
// Package with shared types and constants of the packet rate limit scan filter.
package prlsf_pkg;

  localparam logic [15:0] ETHER_IPV4     = 16'h0800;
  localparam logic [3:0]  IP_VERSION_4   = 4'd4;
  localparam logic [15:0] MIN_FRAME_LEN  = 16'd34;
  localparam logic [7:0]  PROTO_ICMP     = 8'd1;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [7:0]  ICMP_ECHO_REQ  = 8'd8;
  localparam int          TCP_SYN_BIT    = 1;
  localparam int          TCP_ACK_BIT    = 4;
  localparam logic [63:0] WINDOW_RESET   = 64'd1000000000;
  localparam logic [15:0] LIMIT_RESET    = 16'd100;
  localparam int          COUNT_W        = 17;

  localparam logic [15:0] UDP_PORT_DNS   = 16'd53;
  localparam logic [15:0] UDP_PORT_SNMP  = 16'd161;
  localparam logic [15:0] UDP_PORT_NTP   = 16'd123;
  localparam logic [15:0] UDP_PORT_NBNS  = 16'd137;
  localparam logic [15:0] UDP_PORT_NBDG  = 16'd138;
  localparam logic [15:0] UDP_PORT_MSSQL = 16'd1434;

  localparam logic CFG_WINDOW_NS    = 1'b0;
  localparam logic CFG_PACKET_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    SCAN_NONE = 2'd0,
    SCAN_TCP_SYN = 2'd1,
    SCAN_UDP_PORT = 2'd2,
    SCAN_ICMP_ECHO = 2'd3
  } scan_kind_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;
    logic capture;
    logic lookup;
    logic update;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
  } dp_status_t;

endpackage

[design/prlsf_ctrl.sv]
// Controller state machine of the packet rate limit scan filter.
module prlsf_ctrl
  import prlsf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd,
  output logic       busy
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (status.clear_done) state_next = ST_IDLE;
      ST_IDLE:   if (start) state_next = ST_LOOKUP;
      ST_LOOKUP: state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    case (state)
      ST_CLEAR:  cmd.clear_step = 1'b1;
      ST_IDLE: begin
        busy = 1'b0;
        cmd.capture = start;
      end
      ST_LOOKUP: cmd.lookup = 1'b1;
      ST_UPDATE: cmd.update = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

endmodule

[design/prlsf_dp.sv]
// Datapath of the packet rate limit scan filter: rate table, checks and result register.
module prlsf_dp
  import prlsf_pkg::*;
#(
  parameter int SETS = 256,
  parameter int WAYS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  ctrl_cmd_t   cmd,
  output dp_status_t  status,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic [15:0] packet_length,
  input  logic [15:0] ether_type,
  input  logic [3:0]  ip_version,
  input  logic [3:0]  ip_header_words,
  input  logic [7:0]  ip_protocol,
  input  logic [31:0] source_address,
  input  logic [31:0] dest_address,
  input  logic [15:0] source_port,
  input  logic [15:0] dest_port,
  input  logic [7:0]  tcp_flag_bits,
  input  logic [7:0]  icmp_kind,
  input  logic [63:0] now_ns,
  output logic        done,
  output logic        verdict,
  output logic        event_valid,
  output logic [1:0]  scan_kind,
  output logic [31:0] event_source,
  output logic [31:0] event_dest,
  output logic [15:0] event_source_port,
  output logic [15:0] event_dest_port,
  output logic [7:0]  event_protocol,
  output logic [63:0] event_time
);

  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  typedef struct packed {
    logic               valid;
    logic [31:0]        key;
    logic [63:0]        start;
    logic [COUNT_W-1:0] count;
  } entry_t;

  logic [63:0] window_ns;
  logic [15:0] packet_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ns    <= WINDOW_RESET;
      packet_limit <= LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_WINDOW_NS:    window_ns <= cfg_data;
        CFG_PACKET_LIMIT: packet_limit <= cfg_data[15:0];
        default:          ;
      endcase
    end
  end

  // One row per set holds all ways and the set's age ranks.
  entry_t [WAYS-1:0]           row_mem [SETS];
  logic   [WAYS-1:0][WAY_W-1:0] age_mem [SETS];
  entry_t [WAYS-1:0]           row_q;
  logic   [WAYS-1:0][WAY_W-1:0] age_q;

  logic [15:0] len_q;
  logic        ip_ok_q;
  logic [3:0]  ihl_q;
  logic [7:0]  proto_q;
  logic [31:0] src_q, dst_q;
  logic [15:0] sport_q, dport_q;
  logic [7:0]  flags_q, ikind_q;
  logic [63:0] now_q;
  logic [SET_W-1:0] set_q;
  logic [SET_W:0]   clr_cnt;

  logic [7:0] hash_byte;
  logic [SET_W-1:0] set_in;
  assign hash_byte = source_address[7:0] ^ source_address[15:8] ^
                     source_address[23:16] ^ source_address[31:24];
  assign set_in = SET_W'(({24'd0, hash_byte}) % SETS);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      len_q   <= packet_length;
      ip_ok_q <= (packet_length >= MIN_FRAME_LEN) && (ether_type == ETHER_IPV4) &&
                 (ip_version == IP_VERSION_4);
      ihl_q   <= ip_header_words;
      proto_q <= ip_protocol;
      src_q   <= source_address;
      dst_q   <= dest_address;
      sport_q <= source_port;
      dport_q <= dest_port;
      flags_q <= tcp_flag_bits;
      ikind_q <= icmp_kind;
      now_q   <= now_ns;
      set_q   <= set_in;
    end
  end

  // Lookup beat: hit detection and victim choice.
  logic [WAYS-1:0] hit_vec;
  logic            hit;
  logic [WAY_W-1:0] hit_way, inv_way, lru_way, sel_way;
  logic            any_inv;

  always_comb begin
    hit = 1'b0;
    hit_way = '0;
    any_inv = 1'b0;
    inv_way = '0;
    lru_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w] = row_q[w].valid && (row_q[w].key == src_q);
      if (hit_vec[w]) begin
        hit = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (age_q[w] == WAY_W'(WAYS - 1)) lru_way = WAY_W'(w);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!row_q[w].valid) begin
        any_inv = 1'b1;
        inv_way = WAY_W'(w);
      end
    end
    sel_way = hit ? hit_way : (any_inv ? inv_way : lru_way);
  end

  logic             hit_r;
  logic [WAY_W-1:0] way_r;
  entry_t           ent_r;
  logic [63:0]      elapsed_r;

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      hit_r     <= hit;
      way_r     <= sel_way;
      ent_r     <= row_q[sel_way];
      elapsed_r <= now_q - row_q[sel_way].start;
    end
  end

  // Update beat: window test, new row and ranks.
  logic   in_window, over;
  entry_t new_ent;
  entry_t [WAYS-1:0] new_row;
  logic [WAYS-1:0][WAY_W-1:0] new_age;

  always_comb begin
    in_window = hit_r && (elapsed_r < window_ns);
    over = in_window && (ent_r.count > {1'b0, packet_limit});
    new_ent.valid = 1'b1;
    new_ent.key = src_q;
    if (in_window) begin
      new_ent.start = ent_r.start;
      new_ent.count = over ? ent_r.count : ent_r.count + 1'b1;
    end else begin
      new_ent.start = now_q;
      new_ent.count = COUNT_W'(1);
    end
    new_row = row_q;
    new_row[way_r] = new_ent;
    for (int w = 0; w < WAYS; w++) begin
      new_age[w] = (age_q[w] < age_q[way_r]) ? age_q[w] + 1'b1 : age_q[w];
    end
    new_age[way_r] = '0;
  end

  logic tcp_hdr_ok, short_ok;
  logic [16:0] l4_end;
  scan_kind_t kind;

  always_comb begin
    l4_end = 17'd14 + {11'd0, ihl_q, 2'b00};
    tcp_hdr_ok = {1'b0, len_q} >= l4_end + 17'd20;
    short_ok   = {1'b0, len_q} >= l4_end + 17'd8;
    kind = SCAN_NONE;
    case (proto_q)
      PROTO_TCP:
        if (tcp_hdr_ok && flags_q[TCP_SYN_BIT] && !flags_q[TCP_ACK_BIT]) kind = SCAN_TCP_SYN;
      PROTO_UDP:
        if (short_ok && (dport_q == UDP_PORT_DNS || dport_q == UDP_PORT_SNMP ||
            dport_q == UDP_PORT_NTP || dport_q == UDP_PORT_NBNS ||
            dport_q == UDP_PORT_NBDG || dport_q == UDP_PORT_MSSQL)) kind = SCAN_UDP_PORT;
      PROTO_ICMP:
        if (short_ok && ikind_q == ICMP_ECHO_REQ) kind = SCAN_ICMP_ECHO;
      default: kind = SCAN_NONE;
    endcase
    if (!ip_ok_q || over) kind = SCAN_NONE;
  end

  logic [WAYS-1:0][WAY_W-1:0] age_init;
  always_comb begin
    for (int w = 0; w < WAYS; w++) age_init[w] = WAY_W'(w);
  end

  logic [SET_W-1:0] wr_addr;
  logic             wr_en;
  entry_t [WAYS-1:0] wr_row;
  logic [WAYS-1:0][WAY_W-1:0] wr_age;

  always_comb begin
    wr_en = cmd.clear_step || (cmd.update && ip_ok_q);
    wr_addr = cmd.clear_step ? clr_cnt[SET_W-1:0] : set_q;
    wr_row = cmd.clear_step ? '0 : new_row;
    wr_age = cmd.clear_step ? age_init : new_age;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      row_mem[wr_addr] <= wr_row;
      age_mem[wr_addr] <= wr_age;
    end
    if (cmd.capture) begin
      row_q <= row_mem[set_in];
      age_q <= age_mem[set_in];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_step) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end
  assign status.clear_done = (clr_cnt == (SET_W + 1)'(SETS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.update;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      verdict           <= ip_ok_q && (over || kind != SCAN_NONE);
      event_valid       <= kind != SCAN_NONE;
      scan_kind         <= kind;
      event_source      <= (kind != SCAN_NONE) ? src_q : '0;
      event_dest        <= (kind != SCAN_NONE) ? dst_q : '0;
      event_source_port <= (kind == SCAN_TCP_SYN || kind == SCAN_UDP_PORT) ? sport_q : '0;
      event_dest_port   <= (kind == SCAN_TCP_SYN || kind == SCAN_UDP_PORT) ? dport_q : '0;
      event_protocol    <= (kind != SCAN_NONE) ? proto_q : '0;
      event_time        <= (kind != SCAN_NONE) ? now_q : '0;
    end
  end

endmodule

[design/packet_rate_limit_scan_filter_core.sv]
// Top level of the packet rate limit scan filter.
// Each accepted header (start high while busy low) is captured, looked up and checked, and
// gives one result, marked by done for one cycle; a new header is accepted only after the
// read, check and write-back of one table row in the lookup and update states. After reset
// the block clears its rate table, one set per cycle, and holds busy high meanwhile.
// Results cannot be held off by the receiver.
module packet_rate_limit_scan_filter_core
  import prlsf_pkg::*;
#(
  parameter int SETS = 256,
  parameter int WAYS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic [15:0] packet_length,
  input  logic [15:0] ether_type,
  input  logic [3:0]  ip_version,
  input  logic [3:0]  ip_header_words,
  input  logic [7:0]  ip_protocol,
  input  logic [31:0] source_address,
  input  logic [31:0] dest_address,
  input  logic [15:0] source_port,
  input  logic [15:0] dest_port,
  input  logic [7:0]  tcp_flag_bits,
  input  logic [7:0]  icmp_kind,
  input  logic [63:0] now_ns,
  output logic        done,
  output logic        verdict,
  output logic        event_valid,
  output logic [1:0]  scan_kind,
  output logic [31:0] event_source,
  output logic [31:0] event_dest,
  output logic [15:0] event_source_port,
  output logic [15:0] event_dest_port,
  output logic [7:0]  event_protocol,
  output logic [63:0] event_time
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  prlsf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .status(status), .cmd(cmd), .busy(busy)
  );

  prlsf_dp #(.SETS(SETS), .WAYS(WAYS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .packet_length(packet_length), .ether_type(ether_type), .ip_version(ip_version),
    .ip_header_words(ip_header_words), .ip_protocol(ip_protocol),
    .source_address(source_address), .dest_address(dest_address),
    .source_port(source_port), .dest_port(dest_port), .tcp_flag_bits(tcp_flag_bits),
    .icmp_kind(icmp_kind), .now_ns(now_ns), .done(done), .verdict(verdict),
    .event_valid(event_valid), .scan_kind(scan_kind), .event_source(event_source),
    .event_dest(event_dest), .event_source_port(event_source_port),
    .event_dest_port(event_dest_port), .event_protocol(event_protocol),
    .event_time(event_time)
  );

endmodule
